// ===== src/kth_pkg.sv =====
// Package with the shared types and constants of the k-th largest tracker.
`timescale 1ns / 1ps

package kth_pkg;

   // Store size and value width.
   localparam int MAX_K       = 64;
   localparam int VALUE_WIDTH = 32;

   // Widths: store address and fill count (holds MAX_K itself) derived from MAX_K, and rank register.
   localparam int ADDR_WIDTH = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int FILL_WIDTH = $clog2(MAX_K + 1);
   localparam int RANK_WIDTH = 7;
   localparam int CNT_WIDTH  = (FILL_WIDTH > RANK_WIDTH) ? FILL_WIDTH : RANK_WIDTH;

   // Request operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // Response status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // Request payload.
   typedef struct packed {
      logic                          operation;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] kth_value;
      logic                          status;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SHIFT,
      ST_PLACE,
      ST_QUERY
   } state_type;

endpackage

// ===== src/kth_largest_tracker.sv =====
// Top level of the running k-th largest tracker.
`timescale 1ns / 1ps

// Usage:
// Each request on the req_ channel either inserts a signed value or asks for
// the k-th largest value inserted since reset, k being the rank register
// written through csr_write and csr_data (reset value 1). An insert gives no
// response; a query gives one response on the rsp_ channel with the value and
// a status that flags fewer than k values kept (at most MAX_K), or a rank of zero.
// The MAX_K largest values sit in one RAM sorted from largest down. An insert
// walks from the fill position (or the last entry once the store is full)
// toward the head, one read and one shift write per cycle; a first value is
// written straight to the head. The single RAM port pair paces the walk.
// After a query is accepted, its response register is loaded from the store
// read once that register is free; one request is in work at a time.
// Reset clears the fill count and the response valid flag; the RAM needs no
// clearing since only filled entries are read. While the receiver stalls,
// the response holds and inserts are still taken; a further query waits in
// its read state until the response register frees.

module kth_largest_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  kth_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output kth_pkg::rsp_type               rsp_payload,
   input  logic                           csr_write,
   input  logic [kth_pkg::RANK_WIDTH-1:0] csr_data
);

   import kth_pkg::*;

   state_type                     state_ff, state_in;
   logic [ADDR_WIDTH-1:0]         pos_ff, pos_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [FILL_WIDTH-1:0]         fill_ff, fill_in;
   logic                          err_ff, err_in;
   logic [RANK_WIDTH-1:0]         kth_rank_ff, kth_rank_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_payload_ff, rsp_payload_in;

   logic                          ram_wr_en;
   logic [ADDR_WIDTH-1:0]         ram_wr_addr;
   logic [VALUE_WIDTH-1:0]        ram_wr_data;
   logic [ADDR_WIDTH-1:0]         ram_rd_addr;
   logic [VALUE_WIDTH-1:0]        ram_rd_data;
   logic signed [VALUE_WIDTH-1:0] entry;

   logic                          slot_free;
   logic                          fill_full;
   logic                          query_err;
   logic [ADDR_WIDTH-1:0]         query_addr;
   logic [ADDR_WIDTH-1:0]         fill_addr;

   // Sorted store of the largest values.
   kth_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_K)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign entry = $signed(ram_rd_data);

   // Status terms used by the sequencer.
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign fill_full  = (fill_ff == FILL_WIDTH'(MAX_K));
   assign query_err  = (kth_rank_ff == '0) ||
                       (CNT_WIDTH'(kth_rank_ff) > CNT_WIDTH'(fill_ff));
   assign query_addr = ADDR_WIDTH'(kth_rank_ff - RANK_WIDTH'(1));
   assign fill_addr  = ADDR_WIDTH'(fill_ff);

   // Rank register.
   assign kth_rank_in = csr_write ? csr_data : kth_rank_ff;

   // Sequencer: next state, store accesses and response register loading.
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      key_in         = key_ff;
      fill_in        = fill_ff;
      err_in         = err_ff;
      req_stall      = 1'b1;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = pos_ff;
      ram_wr_data    = key_ff;
      ram_rd_addr    = pos_ff - ADDR_WIDTH'(1);
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ram_rd_addr = query_addr;
            if (req_valid) begin
               if (req_payload.operation == OP_QUERY) begin
                  err_in   = query_err;
                  state_in = ST_QUERY;
               end else begin
                  key_in = req_payload.value;
                  if (fill_full) begin
                     // Full store: first compare against the smallest entry.
                     pos_in      = ADDR_WIDTH'(MAX_K - 1);
                     ram_rd_addr = ADDR_WIDTH'(MAX_K - 1);
                     state_in    = ST_CHECK;
                  end else if (fill_ff == '0) begin
                     // Empty store: the value goes straight to the head.
                     fill_in     = fill_ff + FILL_WIDTH'(1);
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = '0;
                     ram_wr_data = req_payload.value;
                  end else begin
                     fill_in     = fill_ff + FILL_WIDTH'(1);
                     pos_in      = fill_addr;
                     ram_rd_addr = fill_addr - ADDR_WIDTH'(1);
                     state_in    = ST_SHIFT;
                  end
               end
            end
         end

         ST_CHECK: begin
            // The read data is the smallest kept entry.
            if (entry >= key_ff) begin
               state_in = ST_IDLE;
            end else if (pos_ff == '0) begin
               state_in = ST_PLACE;
            end else begin
               ram_rd_addr = pos_ff - ADDR_WIDTH'(1);
               state_in    = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // The read data is the entry just above the open position.
            ram_wr_en = 1'b1;
            if (entry < key_ff) begin
               ram_wr_data = ram_rd_data;
               pos_in      = pos_ff - ADDR_WIDTH'(1);
               ram_rd_addr = pos_ff - ADDR_WIDTH'(2);
               if (pos_ff == ADDR_WIDTH'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_PLACE: begin
            ram_wr_en = 1'b1;
            state_in  = ST_IDLE;
         end

         ST_QUERY: begin
            // Hold the read address so the data stays while the response waits.
            ram_rd_addr = query_addr;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_payload_in.kth_value = '0;
                  rsp_payload_in.status    = STATUS_ERROR;
               end else begin
                  rsp_payload_in.kth_value = entry;
                  rsp_payload_in.status    = STATUS_OK;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         kth_rank_ff  <= RANK_WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         kth_rank_ff  <= kth_rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      key_ff         <= key_in;
      err_ff         <= err_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== src/kth_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module kth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; a same-address write returns the old data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/kth_largest_tracker_tb.sv =====
// Self-checking testbench for the running k-th largest tracker.
`timescale 1ns / 1ps

module kth_largest_tracker_tb;
   import kth_pkg::*;

   // Cycles to let an insert finish before the rank register is touched.
   localparam int SETTLE_CYCLES = MAX_K + 8;
   // Cycles without any accepted request or response before giving up.
   localparam int STUCK_LIMIT = 4000;
   // Random requests per rank setting.
   localparam int PHASE_ITEMS = 165;
   // Marks a phase whose rank is drawn at random from the legal range.
   localparam int PICK_ANY = -1;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   // Keeps the largest values seen so far and the answers that queries are owed.
   class kth_rank_keeper;
      value_type                largest[$];
      logic [RANK_WIDTH-1:0]    rank;
      rsp_type                  due_answers[$];
      int unsigned              mismatches;

      function new();
         rank = RANK_WIDTH'(1);
         mismatches = 0;
      endfunction

      function void set_rank(logic [RANK_WIDTH-1:0] r);
         rank = r;
      endfunction

      function int due_count();
         return due_answers.size();
      endfunction

      // Smallest kept value, used to aim inserts at the bottom of the store.
      function value_type floor_value();
         if (largest.size() == 0) begin
            return '0;
         end
         return largest[largest.size() - 1];
      endfunction

      // Apply an accepted request: an insert updates the store, a query owes an answer.
      function void take_request(req_type r);
         value_type v;
         rsp_type   ans;
         int        pos;
         v = r.value;
         if (r.operation == OP_INSERT) begin
            // A full store drops values that are not above its smallest entry.
            if (largest.size() == MAX_K) begin
               if (v <= largest[MAX_K - 1]) begin
                  return;
               end
               void'(largest.pop_back());
            end
            // Equal values go behind the ones already kept.
            pos = largest.size();
            while (pos > 0 && largest[pos - 1] < v) begin
               pos--;
            end
            largest.insert(pos, v);
         end else begin
            if (rank == 0 || rank > MAX_K || largest.size() < rank) begin
               ans.kth_value = '0;
               ans.status    = STATUS_ERROR;
            end else begin
               ans.kth_value = largest[rank - 1];
               ans.status    = STATUS_OK;
            end
            due_answers.push_back(ans);
         end
      endfunction

      // Compare a response with the oldest answer still owed.
      function void check_answer(rsp_type got);
         rsp_type want;
         if (due_answers.size() == 0) begin
            $error("response with no query waiting: kth_value %0d, status %0d",
                   got.kth_value, got.status);
            mismatches++;
            return;
         end
         want = due_answers.pop_front();
         if (got.kth_value !== want.kth_value) begin
            $error("kth_value: expected %0d, got %0d", want.kth_value, got.kth_value);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_write   = 1'b0;
   logic [RANK_WIDTH-1:0] csr_data    = '0;

   kth_rank_keeper keeper = new();
   int unsigned    stuck_cycles = 0;
   int             climb_value  = -1000;
   int unsigned    stall_mode   = 0;
   int unsigned    stall_left   = 0;

   kth_largest_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_data    (csr_data)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver stall pattern: stretches of no stall, random stall and heavy stall.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   // Watch both channels: feed accepted requests to the keeper, check responses,
   // and stop the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            keeper.check_answer(rsp_payload);
         end
         if (req_valid && !req_stall) begin
            keeper.take_request(req_payload);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   function automatic req_type make_request(logic op, value_type v);
      req_type r;
      r.operation = op;
      r.value     = v;
      return r;
   endfunction

   // Value for an insert: extremes, small clustered values, a rising run,
   // values at or next to the store's smallest entry, or anything at all.
   function automatic value_type pick_value();
      value_type v;
      value_type fl;
      case ($urandom_range(0, 9))
         0: begin
            v = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
         end
         1: begin
            v = {1'b1, {(VALUE_WIDTH - 2){1'b0}}, 1'b1};
         end
         2, 3: begin
            v = $signed($urandom_range(0, 16)) - 8;
         end
         4: begin
            climb_value = climb_value + $urandom_range(1, 5000);
            v = climb_value;
         end
         5, 6: begin
            fl = keeper.floor_value();
            if (fl == {1'b0, {(VALUE_WIDTH - 1){1'b1}}}) begin
               v = fl;
            end else begin
               v = fl + $signed($urandom_range(0, 2)) - 1;
            end
         end
         default: begin
            v = $urandom();
         end
      endcase
      // Keep clear of the most negative code, which the value range excludes.
      if (v == {1'b1, {(VALUE_WIDTH - 1){1'b0}}}) begin
         v = v + 1;
      end
      return v;
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic send_request(input req_type r);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Drop valid for a gap of the given length.
   task automatic hold_off(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Wait until every query is answered and any insert in work has finished.
   // The first edge lets the monitor note a request accepted at this very edge.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (keeper.due_count() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Rewrite the rank register while the block is idle.
   task automatic write_rank(input logic [RANK_WIDTH-1:0] r);
      wait_idle();
      csr_write <= 1'b1;
      csr_data  <= r;
      keeper.set_rank(r);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Directed part followed by random phases over a range of rank settings.
   initial begin
      int          phase_ranks[10];
      int          rank_pick;
      int unsigned query_pct;
      int unsigned burst_left;
      bit          steady;
      req_type     r;

      phase_ranks = '{MAX_K, 1, 0, 33, 127, MAX_K + 1, PICK_ANY, PICK_ANY, PICK_ANY, MAX_K};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Query on an empty store, then extremes and repeated values at the reset rank.
      send_request(make_request(OP_QUERY, $urandom()));
      send_request(make_request(OP_INSERT, {1'b0, {(VALUE_WIDTH - 1){1'b1}}}));
      send_request(make_request(OP_QUERY, $urandom()));
      send_request(make_request(OP_INSERT, {1'b1, {(VALUE_WIDTH - 2){1'b0}}, 1'b1}));
      send_request(make_request(OP_INSERT, '0));
      send_request(make_request(OP_INSERT, 5));
      send_request(make_request(OP_INSERT, 5));
      send_request(make_request(OP_INSERT, 5));
      send_request(make_request(OP_QUERY, '0));

      // Ranks landing on a repeated value, on the smallest value, and past the fill.
      write_rank(3);
      send_request(make_request(OP_QUERY, $urandom()));
      write_rank(6);
      send_request(make_request(OP_QUERY, $urandom()));
      write_rank(7);
      send_request(make_request(OP_QUERY, $urandom()));

      // Rank zero and ranks beyond the store size always report an error.
      write_rank(0);
      send_request(make_request(OP_QUERY, $urandom()));
      write_rank({RANK_WIDTH{1'b1}});
      send_request(make_request(OP_QUERY, '1));
      write_rank(RANK_WIDTH'(MAX_K + 1));
      send_request(make_request(OP_QUERY, $urandom()));

      // Random phases: bursts of mixed inserts and queries, with random gaps between bursts unless the phase is steady.
      foreach (phase_ranks[p]) begin
         rank_pick = (phase_ranks[p] == PICK_ANY) ? $urandom_range(1, MAX_K) : phase_ranks[p];
         write_rank(RANK_WIDTH'(rank_pick));
         query_pct  = $urandom_range(15, 50);
         steady     = ($urandom_range(0, 3) == 0);
         burst_left = $urandom_range(1, 40);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(1, 100) <= query_pct) begin
               r = make_request(OP_QUERY, $urandom());
            end else begin
               r = make_request(OP_INSERT, pick_value());
            end
            send_request(r);
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               if (!steady) begin
                  hold_off($urandom_range(1, 8));
               end
            end
         end
      end

      wait_idle();
      if (keeper.mismatches == 0 && keeper.due_count() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== kth_largest_tracker.f =====
src/kth_pkg.sv
src/kth_ram.sv
src/kth_largest_tracker.sv
tb/kth_largest_tracker_tb.sv
